### hw/rtl/rdq_pkg.sv
package rdq_pkg;

  // default sizes
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ITEM_WIDTH  = 32;

  // fixed field widths
  localparam int MASK_W     = 32;
  localparam int OUT_ITEM_W = 32;
  localparam int DEPTH_IN_W = 5;
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_TAIL    = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_REPLACE = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_HEAD     = 3'd2;
  localparam logic [OP_W-1:0] OP_PUSH_HEAD    = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_TAIL     = 3'd4;
  localparam logic [OP_W-1:0] OP_MATCH_REMOVE = 3'd5;
  localparam logic [OP_W-1:0] OP_DRAIN        = 3'd6;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NONE = 2'd2;

endpackage

### hw/rtl/ring_deque_with_match_removal.sv
// channel | handshake              | payload
// --------+------------------------+---------------------------------------------------------
// input   | in_valid / in_stall    | operation, item_value, wanted_value, search_depth
// output  | out_valid / out_stall  | status, item_present, item_out, entry_count, last_result
// config  | cfg_valid / cfg_ready  | cfg_data (match_mask)
//
// one transaction at a time; a stalled result holds the sequencer at its final step
// pushes below full, refused pushes, empty pops and drain, unused code, empty search: result from the execute step
// pop head or pop tail of a non-empty ring, push replace when full: execute reads the store, fetch loads the result
// match removal: the search steps back from the tail one entry at a time (a miss ends at the search limit),
//   then each newer entry is moved down by a read step and a write step through the store
// drain: one result per cycle while the receiver does not stall; synchronous reset empties ring, mask all ones
module ring_deque_with_match_removal
  import rdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ITEM_WIDTH  = DEF_ITEM_WIDTH,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       operation,
  input  logic [ITEM_WIDTH-1:0] item_value,
  input  logic [MASK_W-1:0]     wanted_value,
  input  logic [DEPTH_IN_W-1:0] search_depth,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   status,
  output logic                  item_present,
  output logic [OUT_ITEM_W-1:0] item_out,
  output logic [CNT_W-1:0]      entry_count,
  output logic                  last_result,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [MASK_W-1:0]     cfg_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CMP_W = (CNT_W > DEPTH_IN_W) ? CNT_W : DEPTH_IN_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
  localparam logic [63:0] ITEM_MASK64 =
    (ITEM_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << ITEM_WIDTH) - 64'd1);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_FETCH    = 3'd2;
  localparam logic [2:0] S_SEARCH   = 3'd3;
  localparam logic [2:0] S_SHIFT_RD = 3'd4;
  localparam logic [2:0] S_SHIFT_WR = 3'd5;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST_SLOT : p - 1'b1;
  endfunction

  logic [2:0]            state, state_next;
  logic [PTR_W-1:0]      head, head_next;
  logic [PTR_W-1:0]      tail, tail_next;
  logic [CNT_W-1:0]      occ, occ_next;
  logic [MASK_W-1:0]     match_mask;

  // latched transaction
  logic [OP_W-1:0]       op_r;
  logic [ITEM_WIDTH-1:0] item_r;
  logic [MASK_W-1:0]     wanted_r;
  logic [DEPTH_IN_W-1:0] depth_r;

  // search and shift working registers
  logic [PTR_W-1:0]      pos, pos_next;
  logic [CNT_W-1:0]      left, left_next;
  logic [PTR_W-1:0]      p, p_next;
  logic [ITEM_WIDTH-1:0] cand, cand_next;

  // store port
  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;
  logic [ITEM_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [PTR_W-1:0]      rd_addr;
  logic [ITEM_WIDTH-1:0] rd_data;

  // result load
  logic                  ld;
  logic [STATUS_W-1:0]   ld_status;
  logic                  ld_present;
  logic [ITEM_WIDTH-1:0] ld_item;
  logic                  ld_last;

  logic                  out_free;
  logic                  full, empty;
  logic [CMP_W-1:0]      depth_ext, occ_ext, scan_len;
  logic                  hit;

  rdq_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ITEM_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  // the result register is free when empty or being taken this cycle
  assign out_free  = !out_valid || !out_stall;
  assign full      = (occ == FULL_CNT);
  assign empty     = (occ == '0);

  // entries examined: the smaller of the asked depth and the occupancy
  assign depth_ext = CMP_W'(depth_r);
  assign occ_ext   = CMP_W'(occ);
  assign scan_len  = (depth_ext < occ_ext) ? depth_ext : occ_ext;

  // masked compare against the entry just read
  assign hit = (((64'(rd_data) ^ 64'(wanted_r)) & 64'(match_mask) & ITEM_MASK64) == 64'd0);

  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    occ_next   = occ;
    pos_next   = pos;
    left_next  = left;
    p_next     = p;
    cand_next  = cand;
    wr_en      = 1'b0;
    wr_addr    = tail;
    wr_data    = item_r;
    rd_en      = 1'b0;
    rd_addr    = head;
    ld         = 1'b0;
    ld_status  = STAT_DONE;
    ld_present = 1'b0;
    ld_item    = rd_data;
    ld_last    = 1'b1;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        case (op_r)
          OP_PUSH_TAIL: begin
            if (out_free) begin
              ld = 1'b1;
              state_next = S_IDLE;
              if (full) begin
                ld_status = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                tail_next = ring_next(tail);
                occ_next  = occ + 1'b1;
              end
            end
          end
          OP_PUSH_REPLACE: begin
            if (full) begin
              // fetch the oldest entry before it is overwritten
              rd_en      = 1'b1;
              rd_addr    = head;
              state_next = S_FETCH;
            end else if (out_free) begin
              ld         = 1'b1;
              wr_en      = 1'b1;
              tail_next  = ring_next(tail);
              occ_next   = occ + 1'b1;
              state_next = S_IDLE;
            end
          end
          OP_POP_HEAD, OP_DRAIN: begin
            if (!empty) begin
              rd_en      = 1'b1;
              rd_addr    = head;
              state_next = S_FETCH;
            end else if (out_free) begin
              ld         = 1'b1;
              ld_status  = STAT_NONE;
              state_next = S_IDLE;
            end
          end
          OP_PUSH_HEAD: begin
            if (out_free) begin
              ld = 1'b1;
              state_next = S_IDLE;
              if (full) begin
                ld_status = STAT_FULL;
              end else begin
                head_next = ring_prev(head);
                wr_en     = 1'b1;
                wr_addr   = ring_prev(head);
                occ_next  = occ + 1'b1;
              end
            end
          end
          OP_POP_TAIL: begin
            if (!empty) begin
              rd_en      = 1'b1;
              rd_addr    = ring_prev(tail);
              state_next = S_FETCH;
            end else if (out_free) begin
              ld         = 1'b1;
              ld_status  = STAT_NONE;
              state_next = S_IDLE;
            end
          end
          OP_MATCH_REMOVE: begin
            if (scan_len != '0) begin
              rd_en      = 1'b1;
              rd_addr    = ring_prev(tail);
              pos_next   = ring_prev(tail);
              left_next  = CNT_W'(scan_len);
              state_next = S_SEARCH;
            end else if (out_free) begin
              ld         = 1'b1;
              ld_status  = STAT_NONE;
              state_next = S_IDLE;
            end
          end
          default: begin
            // unused operation code
            if (out_free) begin
              ld         = 1'b1;
              ld_status  = STAT_NONE;
              state_next = S_IDLE;
            end
          end
        endcase
      end

      S_FETCH: begin
        if (out_free) begin
          ld         = 1'b1;
          ld_present = 1'b1;
          state_next = S_IDLE;
          case (op_r)
            OP_PUSH_REPLACE: begin
              // evict head, then write the new item into the freed slot
              head_next = ring_next(head);
              wr_en     = 1'b1;
              tail_next = ring_next(tail);
            end
            OP_POP_HEAD: begin
              head_next = ring_next(head);
              occ_next  = occ - 1'b1;
            end
            OP_POP_TAIL: begin
              tail_next = ring_prev(tail);
              occ_next  = occ - 1'b1;
            end
            OP_DRAIN: begin
              head_next = ring_next(head);
              occ_next  = occ - 1'b1;
              ld_last   = (occ == CNT_W'(1));
              if (occ != CNT_W'(1)) begin
                rd_en      = 1'b1;
                rd_addr    = ring_next(head);
                state_next = S_FETCH;
              end
            end
            default: begin
              ld_present = 1'b0;
              ld_status  = STAT_NONE;
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (hit) begin
          cand_next  = rd_data;
          p_next     = pos;
          state_next = S_SHIFT_RD;
        end else if (left == CNT_W'(1)) begin
          if (out_free) begin
            ld         = 1'b1;
            ld_status  = STAT_NONE;
            state_next = S_IDLE;
          end
        end else begin
          pos_next  = ring_prev(pos);
          left_next = left - 1'b1;
          rd_en     = 1'b1;
          rd_addr   = ring_prev(pos);
        end
      end

      S_SHIFT_RD: begin
        if (ring_next(p) == tail) begin
          // every newer entry has moved down
          if (out_free) begin
            ld         = 1'b1;
            ld_present = 1'b1;
            ld_item    = cand;
            tail_next  = p;
            occ_next   = occ - 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = ring_next(p);
          state_next = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        wr_en      = 1'b1;
        wr_addr    = p;
        wr_data    = rd_data;
        p_next     = ring_next(p);
        state_next = S_SHIFT_RD;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      occ        <= '0;
      match_mask <= '1;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      occ   <= occ_next;
      if (cfg_valid && cfg_ready) begin
        match_mask <= cfg_data;
      end
    end
  end

  // transaction capture and working registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_r     <= operation;
      item_r   <= item_value;
      wanted_r <= wanted_value;
      depth_r  <= search_depth;
    end
    pos  <= pos_next;
    left <= left_next;
    p    <= p_next;
    cand <= cand_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      status       <= ld_status;
      item_present <= ld_present;
      item_out     <= ld_present ? OUT_ITEM_W'(ld_item) : '0;
      entry_count  <= occ_next;
      last_result  <= ld_last;
    end
  end

  // occupancy never exceeds the ring
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= FULL_CNT)
    else $error("occupancy beyond queue depth");

  // occupancy moves by at most one entry per cycle
  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (occ == $past(occ) || occ == $past(occ) + 1'b1 ||
                     occ + 1'b1 == $past(occ)))
    else $error("occupancy jumped");

  // empty or full ring at rest has coinciding pointers
  a_ptr_meet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && (occ == '0 || occ == FULL_CNT)) |-> head == tail)
    else $error("head and tail disagree with occupancy");

  // returning to idle always leaves a final result behind
  a_last_on_idle: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && state == S_IDLE && $past(state) != S_IDLE) |->
      (out_valid && last_result))
    else $error("sequence ended without a final result");

endmodule

### hw/rtl/rdq_store.sv
module rdq_store
  import rdq_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  parameter int WIDTH = DEF_ITEM_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sim/rdq_result_checker.sv
module rdq_result_checker
  import rdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ITEM_WIDTH  = DEF_ITEM_WIDTH,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [OP_W-1:0]       operation,
  input  logic [ITEM_WIDTH-1:0] item_value,
  input  logic [MASK_W-1:0]     wanted_value,
  input  logic [DEPTH_IN_W-1:0] search_depth,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [STATUS_W-1:0]   status,
  input  logic                  item_present,
  input  logic [OUT_ITEM_W-1:0] item_out,
  input  logic [CNT_W-1:0]      entry_count,
  input  logic                  last_result,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [MASK_W-1:0]     cfg_data,
  output int                    mismatch_count,
  output int                    results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic                  present;
    logic [OUT_ITEM_W-1:0] item;
    logic [CNT_W-1:0]      count;
    logic                  last;
  } deque_result_t;

  logic [ITEM_WIDTH-1:0] held_entries[$];  // index 0 is the head
  logic [MASK_W-1:0]     compare_mask;
  deque_result_t         owed_results[$];
  int                    fails = 0;

  assign mismatch_count = fails;

  function automatic void owe(logic [STATUS_W-1:0] st, logic present,
                              logic [ITEM_WIDTH-1:0] item, logic last);
    deque_result_t r;
    r.status  = st;
    r.present = present;
    r.item    = present ? OUT_ITEM_W'(item) : '0;
    r.count   = CNT_W'(held_entries.size());
    r.last    = last;
    owed_results.push_back(r);
  endfunction

  function automatic void predict_deque_op(logic [OP_W-1:0] op, logic [ITEM_WIDTH-1:0] item,
                                           logic [MASK_W-1:0] wanted,
                                           logic [DEPTH_IN_W-1:0] depth);
    logic [ITEM_WIDTH-1:0] taken;
    logic                  full;
    logic                  found;
    int                    n;
    int                    idx;
    full  = held_entries.size() >= QUEUE_DEPTH;
    found = 1'b0;
    case (op)
      OP_PUSH_TAIL: begin
        if (full) begin
          owe(STAT_FULL, 1'b0, '0, 1'b1);
        end else begin
          held_entries.push_back(item);
          owe(STAT_DONE, 1'b0, '0, 1'b1);
        end
      end
      OP_PUSH_REPLACE: begin
        taken = '0;
        if (full) taken = held_entries.pop_front();
        held_entries.push_back(item);
        owe(STAT_DONE, full, taken, 1'b1);
      end
      OP_POP_HEAD: begin
        if (held_entries.size() == 0) begin
          owe(STAT_NONE, 1'b0, '0, 1'b1);
        end else begin
          taken = held_entries.pop_front();
          owe(STAT_DONE, 1'b1, taken, 1'b1);
        end
      end
      OP_PUSH_HEAD: begin
        if (full) begin
          owe(STAT_FULL, 1'b0, '0, 1'b1);
        end else begin
          held_entries.push_front(item);
          owe(STAT_DONE, 1'b0, '0, 1'b1);
        end
      end
      OP_POP_TAIL: begin
        if (held_entries.size() == 0) begin
          owe(STAT_NONE, 1'b0, '0, 1'b1);
        end else begin
          taken = held_entries.pop_back();
          owe(STAT_DONE, 1'b1, taken, 1'b1);
        end
      end
      OP_MATCH_REMOVE: begin
        n = (int'(depth) < held_entries.size()) ? int'(depth) : held_entries.size();
        for (int i = 0; i < n && !found; i++) begin
          idx = held_entries.size() - 1 - i;
          if (((held_entries[idx] ^ ITEM_WIDTH'(wanted)) & ITEM_WIDTH'(compare_mask)) == '0) begin
            found = 1'b1;
            taken = held_entries[idx];
            held_entries.delete(idx);
          end
        end
        if (found) owe(STAT_DONE, 1'b1, taken, 1'b1);
        else owe(STAT_NONE, 1'b0, '0, 1'b1);
      end
      OP_DRAIN: begin
        if (held_entries.size() == 0) begin
          owe(STAT_NONE, 1'b0, '0, 1'b1);
        end else begin
          while (held_entries.size() > 0) begin
            taken = held_entries.pop_front();
            owe(STAT_DONE, 1'b1, taken, held_entries.size() == 0);
          end
        end
      end
      default: owe(STAT_NONE, 1'b0, '0, 1'b1);
    endcase
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (rst) begin
      held_entries.delete();
      owed_results.delete();
      compare_mask = '1;
    end else begin
      // results first: a result never belongs to a transaction taken at the same edge
      if (out_valid && !out_stall) begin
        got = '{status, item_present, item_out, entry_count, last_result};
        if (owed_results.size() == 0) begin
          if (fails < 10)
            $display("%0t: result with nothing owed: st=%0d pres=%0d item=%h cnt=%0d last=%0d",
                     $realtime, status, item_present, item_out, entry_count, last_result);
          fails++;
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            if (fails < 10)
              $display("%0t: mismatch exp st=%0d pres=%0d item=%h cnt=%0d last=%0d, got st=%0d pres=%0d item=%h cnt=%0d last=%0d",
                       $realtime, want.status, want.present, want.item, want.count,
                       want.last, got.status, got.present, got.item, got.count, got.last);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) compare_mask = cfg_data;
      if (in_valid && !in_stall)
        predict_deque_op(operation, item_value, wanted_value, search_depth);
    end
    results_owed <= owed_results.size();
  end

endmodule

### sim/tb_ring_deque_with_match_removal.sv
module tb_ring_deque_with_match_removal;
  import rdq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
  localparam int ITEM_WIDTH  = DEF_ITEM_WIDTH;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  // the one code the package leaves unnamed: the block must treat it as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 150;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       operation;
  logic [ITEM_WIDTH-1:0] item_value;
  logic [MASK_W-1:0]     wanted_value;
  logic [DEPTH_IN_W-1:0] search_depth;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   status;
  logic                  item_present;
  logic [OUT_ITEM_W-1:0] item_out;
  logic [CNT_W-1:0]      entry_count;
  logic                  last_result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [MASK_W-1:0]     cfg_data;

  int mismatch_count;
  int results_owed;

  // idling controls shared by both sides
  logic no_idle = 1'b0;
  logic hold_request = 1'b0;
  logic hold_active = 1'b0;

  // handles recently pushed, so that match removal finds something most of the time
  logic [ITEM_WIDTH-1:0] recent_items[16];
  int                    recent_wr = 0;
  logic [ITEM_WIDTH-1:0] handle_pool[8];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ring_deque_with_match_removal dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .item_value   (item_value),
    .wanted_value (wanted_value),
    .search_depth (search_depth),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .item_present (item_present),
    .item_out     (item_out),
    .entry_count  (entry_count),
    .last_result  (last_result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  rdq_result_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .item_value     (item_value),
    .wanted_value   (wanted_value),
    .search_depth   (search_depth),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .item_present   (item_present),
    .item_out       (item_out),
    .entry_count    (entry_count),
    .last_result    (last_result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // receiver: random stalls, none during a no-idle stretch, solid during a hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_active || (!no_idle && $urandom_range(0, 99) < 36);
    end
  end

  // long hold-off of the receiver, counted here so the sender keeps offering meanwhile
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
      end
    end
  end

  // offer one transaction and wait for it to be taken; valid is left high afterwards
  // so that back-to-back transactions never see valid dropped and raised in one step
  task automatic offer_item(logic [OP_W-1:0] op, logic [ITEM_WIDTH-1:0] item,
                            logic [MASK_W-1:0] wanted, logic [DEPTH_IN_W-1:0] depth);
    int gap;
    if (!no_idle && $urandom_range(0, 99) < 36) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    item_value   <= item;
    wanted_value <= wanted;
    search_depth <= depth;
    if (op == OP_PUSH_TAIL || op == OP_PUSH_REPLACE || op == OP_PUSH_HEAD) begin
      recent_items[recent_wr] = item;
      recent_wr = (recent_wr + 1) % 16;
    end
    do @(posedge clk); while (in_stall);
  endtask

  // sender pauses until every owed result has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic write_match_mask(logic [MASK_W-1:0] mask);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= mask;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // op mix biased by mode: growing, shrinking or mixed
  function automatic logic [OP_W-1:0] pick_operation(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 40) return OP_PUSH_TAIL;
        if (r < 55) return OP_PUSH_HEAD;
        if (r < 70) return OP_PUSH_REPLACE;
        if (r < 78) return OP_POP_HEAD;
        if (r < 84) return OP_POP_TAIL;
        if (r < 94) return OP_MATCH_REMOVE;
        if (r < 97) return OP_DRAIN;
        return OP_UNUSED;
      end
      1: begin
        if (r < 10) return OP_PUSH_TAIL;
        if (r < 15) return OP_PUSH_HEAD;
        if (r < 20) return OP_PUSH_REPLACE;
        if (r < 40) return OP_POP_HEAD;
        if (r < 58) return OP_POP_TAIL;
        if (r < 92) return OP_MATCH_REMOVE;
        if (r < 96) return OP_DRAIN;
        return OP_UNUSED;
      end
      default: begin
        if (r < 20) return OP_PUSH_TAIL;
        if (r < 30) return OP_PUSH_HEAD;
        if (r < 42) return OP_PUSH_REPLACE;
        if (r < 55) return OP_POP_HEAD;
        if (r < 66) return OP_POP_TAIL;
        if (r < 90) return OP_MATCH_REMOVE;
        if (r < 95) return OP_DRAIN;
        return OP_UNUSED;
      end
    endcase
  endfunction

  // handles: partly from a small pool with a flipped middle byte, so that
  // masked matches hit under narrow masks, partly fully random, rarely zero
  function automatic logic [ITEM_WIDTH-1:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return '0;
    if (r < 50) return handle_pool[$urandom_range(0, 7)] ^
                       ($urandom_range(0, 1) ? ($urandom & 32'h0000_FF00) : 32'h0);
    return $urandom;
  endfunction

  function automatic logic [MASK_W-1:0] pick_wanted();
    if ($urandom_range(0, 99) < 65) return recent_items[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  function automatic logic [DEPTH_IN_W-1:0] pick_depth();
    if ($urandom_range(0, 99) < 20) return DEPTH_IN_W'(QUEUE_DEPTH);
    return DEPTH_IN_W'($urandom_range(0, QUEUE_DEPTH));
  endfunction

  // safety net against a hung handshake
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [MASK_W-1:0] phase_masks[6];
    int                mode;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    operation    <= OP_PUSH_TAIL;
    item_value   <= '0;
    wanted_value <= '0;
    search_depth <= '0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    for (int i = 0; i < 16; i++) recent_items[i] = $urandom;
    for (int i = 0; i < 8; i++) handle_pool[i] = $urandom;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty queue cases, then a small known queue
    write_match_mask(32'hFFFF_FFFF);
    offer_item(OP_POP_HEAD, $urandom, $urandom, '0);
    offer_item(OP_POP_TAIL, $urandom, $urandom, '0);
    offer_item(OP_DRAIN, $urandom, $urandom, '0);
    offer_item(OP_MATCH_REMOVE, $urandom, $urandom, 5'd16);
    offer_item(OP_UNUSED, $urandom, $urandom, 5'd31);
    offer_item(OP_PUSH_TAIL, 32'h0, $urandom, '0);            // zero handle
    offer_item(OP_PUSH_TAIL, 32'hFFFF_FFFF, $urandom, '0);
    offer_item(OP_PUSH_HEAD, 32'h8000_0001, $urandom, '0);
    offer_item(OP_PUSH_TAIL, 32'h5A5A_A5A5, $urandom, '0);
    offer_item(OP_MATCH_REMOVE, $urandom, 32'hFFFF_FFFF, 5'd0); // depth zero finds nothing
    offer_item(OP_MATCH_REMOVE, $urandom, 32'h8000_0001, 5'd1); // match beyond the depth
    offer_item(OP_MATCH_REMOVE, $urandom, 32'hFFFF_FFFF, 5'd16); // mid-queue match, shift down
    offer_item(OP_MATCH_REMOVE, $urandom, 32'h1234_5678, 5'd16); // deep search, no match
    offer_item(OP_POP_TAIL, $urandom, $urandom, '0);
    offer_item(OP_POP_HEAD, $urandom, $urandom, '0);
    offer_item(OP_DRAIN, $urandom, $urandom, '0);

    // fill to the brim while the receiver holds off, so the input backs up
    settle();
    hold_request = 1'b1;
    for (int i = 0; i < QUEUE_DEPTH; i++) offer_item(OP_PUSH_TAIL, $urandom, $urandom, '0);
    offer_item(OP_PUSH_TAIL, $urandom, $urandom, '0);      // full: refused
    offer_item(OP_PUSH_HEAD, $urandom, $urandom, '0);      // full: refused
    offer_item(OP_PUSH_REPLACE, $urandom, $urandom, '0);   // full: evicts the head
    offer_item(OP_PUSH_REPLACE, $urandom, $urandom, '0);
    offer_item(OP_DRAIN, $urandom, $urandom, '0);          // sixteen results

    // random phases, each under its own mask, extremes included
    phase_masks[0] = 32'h0000_0000;
    phase_masks[1] = 32'h0000_00FF;
    phase_masks[2] = 32'hFFFF_0000;
    phase_masks[3] = $urandom;
    phase_masks[4] = 32'h8000_0000;
    phase_masks[5] = 32'hFFFF_FFFF;
    for (int p = 0; p < 6; p++) begin
      write_match_mask(phase_masks[p]);
      no_idle <= (p == 2);
      for (int i = 0; i < 50; i++) begin
        if (i % 16 == 0) mode = $urandom_range(0, 2);
        offer_item(pick_operation(mode), pick_handle(), pick_wanted(), pick_depth());
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
